@@ hw/rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion macros. Define NO_ASSERTIONS to leave them out.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Condition must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
        else $error("assertion failed: condition does not hold");

// Antecedent in one cycle implies consequent in the same cycle.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: implication does not hold");

// Antecedent in one cycle implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication does not hold");

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, cond)
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

@@ hw/rtl/rsmm_pkg.sv @@
// ---------------------------------------------------------------------------
// rsmm_pkg
// Types, constants and helpers shared by the running statistics block.
// ---------------------------------------------------------------------------
package rsmm_pkg;

    localparam int SAMPLE_BITS = 32;
    localparam int MAX_COUNT   = 65535;

    localparam int IN_W    = 32;
    localparam int TOTAL_W = 48;
    localparam int MEAN_W  = 32;
    localparam int VAL_W   = 32;
    localparam int COUNT_W = 16;

    localparam int DIV_STEPS = TOTAL_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(MAX_COUNT);

    // Extremes a sample can take; reset values of the running max and min.
    localparam logic signed [VAL_W-1:0] SAMPLE_TOP =
        VAL_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [VAL_W-1:0] SAMPLE_BOTTOM =
        VAL_W'(-((64'sd1 <<< (SAMPLE_BITS - 1))));

    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    typedef struct packed {
        logic                      command;
        logic signed [IN_W-1:0]    sample;
    } in_t;

    typedef struct packed {
        logic signed [TOTAL_W-1:0] total;
        logic signed [MEAN_W-1:0]  mean;
        logic signed [VAL_W-1:0]   largest;
        logic signed [VAL_W-1:0]   smallest;
        logic [COUNT_W-1:0]        sample_count;
        logic                      overflowed;
    } out_t;

    typedef enum logic [1:0] {
        CTL_ACCUM,
        CTL_DIVIDE,
        CTL_LOAD
    } ctl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic add;      // fold a sample into the running state
        logic finish;   // snapshot, clear, start the divider
        logic load;     // write the result register
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic div_done;
    } dp_status_t;

    // Keep the low SAMPLE_BITS bits and sign extend them.
    function automatic logic signed [VAL_W-1:0] widen_sample(
        input logic [IN_W-1:0] raw
    );
        logic [SAMPLE_BITS-1:0] field;
        begin
            field = raw[SAMPLE_BITS-1:0];
            return VAL_W'($signed(field));
        end
    endfunction

endpackage

@@ hw/rtl/running_sum_min_max_mean.sv @@
// ---------------------------------------------------------------------------
// running_sum_min_max_mean
// Running sum, min, max and count over signed samples; a finish beat emits
// the statistics with a truncated mean and clears the run.
// ---------------------------------------------------------------------------
//  channel | ports                        | payload
//  --------+------------------------------+-------------------------------
//  input   | s_valid, s_ready, s_payload  | command, sample
//  result  | m_valid, m_ready, m_payload  | total, mean, largest, smallest,
//          |                              | sample_count, overflowed
//
//  Adds stream back to back while no finish is in progress.
//  A finish beat holds s_ready low through the 48 steps of the bit-serial
//  mean divider, until the controller sees it finish and loads the result.
//  Adds keep streaming while a result waits in the output register; a finish
//  waits there only for the register to drain.
//  Reset (aresetn low, synchronous) clears the run and drops any pending result.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module running_sum_min_max_mean (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  rsmm_pkg::in_t    s_payload,
    output logic             m_valid,
    input  logic             m_ready,
    output rsmm_pkg::out_t   m_payload
);

    rsmm_pkg::dp_cmd_t    cmd;
    rsmm_pkg::dp_status_t status;

    rsmm_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_command (s_payload.command),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .status    (status),
        .cmd       (cmd)
    );

    rsmm_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_beat  (s_payload),
        .cmd      (cmd),
        .status   (status),
        .out_beat (m_payload)
    );

    `ASSERT_NEXT(a_finish_stalls, aclk, aresetn, cmd.finish, !s_ready)
    `ASSERT_IMPLY(a_load_slot_free, aclk, aresetn, cmd.load, !(m_valid && !m_ready))
    `ASSERT_IMPLY(a_valid_from_load, aclk, aresetn, $rose(m_valid), $past(cmd.load))
    `ASSERT_ALWAYS(a_single_cmd, aclk, aresetn, $onehot0({cmd.add, cmd.finish, cmd.load}))

endmodule

@@ hw/rtl/rsmm_div.sv @@
// ---------------------------------------------------------------------------
// rsmm_div
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module rsmm_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [rsmm_pkg::TOTAL_W-1:0]  dividend,
    input  logic [rsmm_pkg::COUNT_W-1:0]  divisor,
    output logic [rsmm_pkg::TOTAL_W-1:0]  quotient,
    output logic                          done
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [rsmm_pkg::STEP_W-1:0]   step_reg, step_next;
    logic [rsmm_pkg::TOTAL_W-1:0]  quo_reg, quo_next;
    logic [rsmm_pkg::COUNT_W-1:0]  rem_reg, rem_next;
    logic [rsmm_pkg::COUNT_W-1:0]  dvs_reg, dvs_next;
    logic [rsmm_pkg::COUNT_W:0]    trial;
    logic [rsmm_pkg::COUNT_W:0]    diff;
    logic                          qbit;

    always_comb begin
        trial = {rem_reg, quo_reg[rsmm_pkg::TOTAL_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        qbit  = (trial >= {1'b0, dvs_reg});
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            // shift the dividend out at the top, the quotient bit in at the bottom
            quo_next = {quo_reg[rsmm_pkg::TOTAL_W-2:0], qbit};
            rem_next = qbit ? diff[rsmm_pkg::COUNT_W-1:0] : trial[rsmm_pkg::COUNT_W-1:0];
            step_next = step_reg + 1'b1;
            if (step_reg == rsmm_pkg::STEP_W'(rsmm_pkg::DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

@@ hw/rtl/rsmm_dp.sv @@
// ---------------------------------------------------------------------------
// rsmm_dp
// Running total, min, max and count, the finish snapshot, the mean divider
// and the result register.
// ---------------------------------------------------------------------------
module rsmm_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  rsmm_pkg::in_t        in_beat,
    input  rsmm_pkg::dp_cmd_t    cmd,
    output rsmm_pkg::dp_status_t status,
    output rsmm_pkg::out_t       out_beat
);

    logic signed [rsmm_pkg::TOTAL_W-1:0] total_reg, total_next;
    logic signed [rsmm_pkg::VAL_W-1:0]   min_reg, min_next;
    logic signed [rsmm_pkg::VAL_W-1:0]   max_reg, max_next;
    logic [rsmm_pkg::COUNT_W-1:0]        count_reg, count_next;
    logic                                ovf_reg, ovf_next;

    rsmm_pkg::out_t                      snap_reg, snap_next;
    rsmm_pkg::out_t                      out_reg, out_next;

    logic signed [rsmm_pkg::VAL_W-1:0]   value;
    logic [rsmm_pkg::TOTAL_W-1:0]        magnitude;
    logic [rsmm_pkg::TOTAL_W-1:0]        quotient;
    logic [rsmm_pkg::TOTAL_W-1:0]        signed_quo;
    logic                                div_done;

    assign value     = rsmm_pkg::widen_sample(in_beat.sample);
    assign magnitude = total_reg[rsmm_pkg::TOTAL_W-1] ? -total_reg : total_reg;

    always_comb begin
        total_next = total_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        snap_next  = snap_reg;
        if (cmd.finish) begin
            snap_next.total        = total_reg;
            snap_next.mean         = '0;
            snap_next.largest      = max_reg;
            snap_next.smallest     = min_reg;
            snap_next.sample_count = count_reg;
            snap_next.overflowed   = ovf_reg;
            total_next = '0;
            min_next   = rsmm_pkg::SAMPLE_TOP;
            max_next   = rsmm_pkg::SAMPLE_BOTTOM;
            count_next = '0;
            ovf_next   = 1'b0;
        end else if (cmd.add) begin
            if (count_reg >= rsmm_pkg::COUNT_LIMIT) begin
                // saturated: drop the sample, flag it
                ovf_next = 1'b1;
            end else begin
                total_next = total_reg + rsmm_pkg::TOTAL_W'(value);
                if (value < min_reg) begin
                    min_next = value;
                end
                if (value > max_reg) begin
                    max_next = value;
                end
                count_next = count_reg + 1'b1;
            end
        end
    end

    rsmm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.finish),
        .dividend (magnitude),
        .divisor  (count_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    // Truncation toward zero: divide magnitudes, restore the sign.
    assign signed_quo = snap_reg.total[rsmm_pkg::TOTAL_W-1] ? -quotient : quotient;

    always_comb begin
        out_next = out_reg;
        if (cmd.load) begin
            out_next = snap_reg;
            if (snap_reg.sample_count != '0) begin
                out_next.mean = signed_quo[rsmm_pkg::MEAN_W-1:0];
            end else begin
                out_next.mean = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= '0;
            min_reg   <= rsmm_pkg::SAMPLE_TOP;
            max_reg   <= rsmm_pkg::SAMPLE_BOTTOM;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            total_reg <= total_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        snap_reg <= snap_next;
        out_reg  <= out_next;
    end

    assign status.div_done = div_done;
    assign out_beat        = out_reg;

endmodule

@@ hw/rtl/rsmm_ctrl.sv @@
// ---------------------------------------------------------------------------
// rsmm_ctrl
// Sequencer: accepts beats, waits out the mean division, hands the result
// to the output register.
// ---------------------------------------------------------------------------
module rsmm_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_command,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  rsmm_pkg::dp_status_t status,
    output rsmm_pkg::dp_cmd_t    cmd
);

    rsmm_pkg::ctl_state_t state_reg, state_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 slot_free;

    assign slot_free = !out_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rsmm_pkg::CTL_ACCUM: begin
                if (s_valid && s_command == rsmm_pkg::CMD_FINISH) begin
                    state_next = rsmm_pkg::CTL_DIVIDE;
                end
            end
            rsmm_pkg::CTL_DIVIDE: begin
                if (status.div_done) begin
                    state_next = rsmm_pkg::CTL_LOAD;
                end
            end
            rsmm_pkg::CTL_LOAD: begin
                if (slot_free) begin
                    state_next = rsmm_pkg::CTL_ACCUM;
                end
            end
            default: begin
                state_next = rsmm_pkg::CTL_ACCUM;
            end
        endcase
    end

    always_comb begin
        s_ready    = 1'b0;
        cmd.add    = 1'b0;
        cmd.finish = 1'b0;
        cmd.load   = 1'b0;
        case (state_reg)
            rsmm_pkg::CTL_ACCUM: begin
                s_ready    = 1'b1;
                cmd.add    = s_valid && (s_command == rsmm_pkg::CMD_ADD);
                cmd.finish = s_valid && (s_command == rsmm_pkg::CMD_FINISH);
            end
            rsmm_pkg::CTL_DIVIDE: begin
                s_ready = 1'b0;
            end
            rsmm_pkg::CTL_LOAD: begin
                cmd.load = slot_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= rsmm_pkg::CTL_ACCUM;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid = out_valid_reg;

endmodule
